// File: src/rrf_pkg.sv
// rrf_pkg: shared constants and types for the rolling fingerprint block.
// No dependencies; used by every module under src except rrf_ram.
`timescale 1ns / 1ps

package rrf_pkg;

  // window length in bytes
  localparam int WINDOW_BYTES = 48;

  // field widths
  localparam int WORD_W = 63;
  localparam int BYTE_W = 8;

  // window position and fill counter widths
  localparam int POS_W  = $clog2(WINDOW_BYTES);
  localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

  // basis sweep: x^k mod P is captured at these step numbers
  localparam int LEAVE_STEP  = 8 * WINDOW_BYTES;
  localparam int REDUCE_STEP = WORD_W;
  localparam int LAST_STEP   = (LEAVE_STEP > REDUCE_STEP) ? (LEAVE_STEP + 7)
                                                          : (REDUCE_STEP + 7);
  localparam int STEP_W      = $clog2(LAST_STEP + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // precomputed words: leave[j] = x^(8W+j) mod P, reduce[i] = x^(63+i) mod P
  typedef struct packed {
    word_t [7:0] leave;
    word_t [7:0] reduce;
  } basis_set_t;

  // one beat held between the window stage and the fold
  typedef struct packed {
    byte_t data_byte;
    logic  restart;
    byte_t old_byte;
    logic  window_full;
  } stage_t;

endpackage

// File: src/rabin_rolling_fingerprint.sv
// Rolling Rabin fingerprint top level: handshakes, fold logic, result register.
// Depends on rrf_pkg, rrf_basis, rrf_window.
`timescale 1ns / 1ps

// Takes one byte per beat and returns one 63-bit fingerprint beat per input beat, over the last
// 48 bytes, modulo x^63 + poly_low_terms. Throughput is one byte per clock while no basis sweep
// runs and the output is not stalled; the byte is caught in the window read stage at the
// accepting edge and its result is loaded into the result register, raising out_valid, once
// that register is free. After reset and after every write of poly_low_terms, the basis unit
// steps x^k mod P one power per cycle until every basis word is captured; in_ready and
// cfg_ready are low for that time. A polynomial write keeps the current window and
// fingerprint as they are.
module rabin_rolling_fingerprint (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  rrf_pkg::word_t poly_low_terms,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrf_pkg::byte_t data_byte,
  input  logic           restart,
  output logic           out_valid,
  input  logic           out_ready,
  output rrf_pkg::word_t fingerprint,
  output logic           window_full
);

  logic                busy;
  rrf_pkg::basis_set_t basis;
  rrf_pkg::stage_t     stage;
  logic                in_accept;
  logic                s1_valid;
  logic                s1_move;
  rrf_pkg::word_t      running_print;
  rrf_pkg::word_t      cur;
  rrf_pkg::word_t      reduce_sum;
  rrf_pkg::word_t      leave_sum;
  rrf_pkg::word_t      print_next;

  rrf_basis u_basis (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (poly_low_terms),
    .busy     (busy),
    .basis    (basis)
  );

  rrf_window u_window (
    .clk      (clk),
    .rst      (rst),
    .take     (in_accept),
    .data_byte(data_byte),
    .restart  (restart),
    .stage    (stage)
  );

  // flow control: stage 1 moves into the result register when it is free
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !busy && (!s1_valid || s1_move);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // fold: cur * x^8 + byte - old * x^(8W), all mod P
  assign cur = stage.restart ? '0 : running_print;

  always_comb begin
    reduce_sum = '0;
    leave_sum  = '0;
    for (int i = 0; i < 8; i++) begin
      if (cur[55 + i]) begin
        reduce_sum = reduce_sum ^ basis.reduce[i];
      end
      if (stage.old_byte[i]) begin
        leave_sum = leave_sum ^ basis.leave[i];
      end
    end
  end

  assign print_next = {cur[54:0], stage.data_byte} ^ reduce_sum ^ leave_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_print <= '0;
    end else if (s1_move) begin
      running_print <= print_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      fingerprint <= print_next;
      window_full <= stage.window_full;
    end
  end

  // no beat enters while the basis is being rebuilt
  assert property (@(posedge clk) disable iff (rst) busy |-> !in_accept)
    else $error("input beat accepted during basis sweep");

  // a held stage-1 beat is never overwritten
  assert property (@(posedge clk) disable iff (rst) (s1_valid && !s1_move) |-> !in_accept)
    else $error("stage 1 overwritten while stalled");

  // a result only follows a beat in stage 1
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(s1_valid))
    else $error("result without a stage-1 beat");

  // a polynomial write always starts a sweep
  assert property (@(posedge clk) disable iff (rst) (cfg_valid && cfg_ready) |=> busy)
    else $error("polynomial write did not start basis sweep");

endmodule

// File: src/rrf_ram.sv
// rrf_ram: generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
`timescale 1ns / 1ps

module rrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/rrf_basis.sv
// rrf_basis: polynomial register and the basis sweep (one multiply by x per cycle).
// Depends on rrf_pkg.
`timescale 1ns / 1ps

module rrf_basis (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rrf_pkg::word_t      cfg_data,
  output logic                busy,
  output rrf_pkg::basis_set_t basis
);

  rrf_pkg::word_t              poly;
  rrf_pkg::word_t              v;
  logic [rrf_pkg::STEP_W-1:0]  step;
  logic [rrf_pkg::STEP_W-1:0]  leave_off;
  logic [rrf_pkg::STEP_W-1:0]  reduce_off;
  logic                        in_leave;
  logic                        in_reduce;
  rrf_pkg::word_t              v_next;
  logic                        cfg_accept;

  assign cfg_ready  = !busy;
  assign cfg_accept = cfg_valid && cfg_ready;

  // v * x mod P
  assign v_next = {v[rrf_pkg::WORD_W-2:0], 1'b0} ^ (v[rrf_pkg::WORD_W-1] ? poly : '0);

  // capture windows of the sweep
  assign leave_off  = step - rrf_pkg::STEP_W'(rrf_pkg::LEAVE_STEP);
  assign reduce_off = step - rrf_pkg::STEP_W'(rrf_pkg::REDUCE_STEP);
  assign in_leave   = (step >= rrf_pkg::STEP_W'(rrf_pkg::LEAVE_STEP)) &&
                      (step <= rrf_pkg::STEP_W'(rrf_pkg::LEAVE_STEP + 7));
  assign in_reduce  = (step >= rrf_pkg::STEP_W'(rrf_pkg::REDUCE_STEP)) &&
                      (step <= rrf_pkg::STEP_W'(rrf_pkg::REDUCE_STEP + 7));

  // sweep control: restart on reset and on every polynomial write
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= rrf_pkg::WORD_W'(1);
      v    <= rrf_pkg::WORD_W'(1);
      step <= '0;
      busy <= 1'b1;
    end else if (cfg_accept) begin
      poly <= cfg_data;
      v    <= rrf_pkg::WORD_W'(1);
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      v    <= v_next;
      step <= step + rrf_pkg::STEP_W'(1);
      if (step == rrf_pkg::STEP_W'(rrf_pkg::LAST_STEP)) begin
        busy <= 1'b0;
      end
    end
  end

  // basis words, filled during the sweep
  always_ff @(posedge clk) begin
    if (busy && in_leave) begin
      basis.leave[leave_off[2:0]] <= v;
    end
    if (busy && in_reduce) begin
      basis.reduce[reduce_off[2:0]] <= v;
    end
  end

endmodule

// File: src/rrf_window.sv
// rrf_window: window byte store, write position and fill count; registers one beat.
// Depends on rrf_pkg and rrf_ram.
`timescale 1ns / 1ps

module rrf_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  rrf_pkg::byte_t  data_byte,
  input  logic            restart,
  output rrf_pkg::stage_t stage
);

  logic [rrf_pkg::POS_W-1:0]  pos;
  logic [rrf_pkg::POS_W-1:0]  pos_eff;
  logic [rrf_pkg::POS_W-1:0]  pos_next;
  logic [rrf_pkg::FILL_W-1:0] fill;
  logic [rrf_pkg::FILL_W-1:0] fill_eff;
  logic [rrf_pkg::FILL_W-1:0] fill_next;
  logic                       old_valid;
  logic                       old_valid_q;
  rrf_pkg::byte_t             ram_rdata;
  rrf_pkg::byte_t             byte_q;
  logic                       restart_q;
  logic                       full_q;

  // restart clears position and fill before this byte
  assign pos_eff   = restart ? '0 : pos;
  assign fill_eff  = restart ? '0 : fill;
  // slot holds a live byte only once the window has filled
  assign old_valid = (fill_eff == rrf_pkg::FILL_W'(rrf_pkg::WINDOW_BYTES));
  assign fill_next = old_valid ? fill_eff : fill_eff + rrf_pkg::FILL_W'(1);
  assign pos_next  = (pos_eff == rrf_pkg::POS_W'(rrf_pkg::WINDOW_BYTES - 1)) ?
                     '0 : pos_eff + rrf_pkg::POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
    end else if (take) begin
      pos  <= pos_next;
      fill <= fill_next;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_q      <= data_byte;
      restart_q   <= restart;
      old_valid_q <= old_valid;
      full_q      <= (fill_next == rrf_pkg::FILL_W'(rrf_pkg::WINDOW_BYTES));
    end
  end

  // read the leaving byte and overwrite it with the new one in the same cycle
  rrf_ram #(
    .WIDTH(rrf_pkg::BYTE_W),
    .DEPTH(rrf_pkg::WINDOW_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (take),
    .waddr(pos_eff),
    .wdata(data_byte),
    .re   (take),
    .raddr(pos_eff),
    .rdata(ram_rdata)
  );

  assign stage.data_byte   = byte_q;
  assign stage.restart     = restart_q;
  assign stage.old_byte    = old_valid_q ? ram_rdata : '0;
  assign stage.window_full = full_q;

endmodule
